// File: rtl/fcmc_pkg.sv
package fcmc_pkg;

    // Channel and history geometry
    localparam int CHANNELS       = 4;
    localparam int SAMPLES        = 5;
    localparam int STORE_INTERVAL = 10;
    localparam int CH_W           = $clog2(CHANNELS);
    localparam int SLOT_W         = $clog2(SAMPLES);
    localparam int RANK_W         = $clog2(SAMPLES + 1);
    localparam int MEDIAN_RANK    = SAMPLES / 2;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int ELAPSED_W  = 8;
    localparam int TIME_W     = 10;
    localparam int OFFSET_W   = 10;
    localparam int GAIN_W     = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int GAIN_RESET = 1000;

    // Calibration arithmetic
    localparam int SUM_W       = SAMPLE_W + 2;
    localparam int MUL_W       = 21;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int LEVEL_MAX   = 1023;
    localparam int SCALE_DIV   = 1000;
    localparam int CLAMP_LIMIT = (LEVEL_MAX + 1) * SCALE_DIV;
    localparam int QUOT_W      = 20;
    localparam int DIV_SHIFT   = 29;
    // ceil(2^29 / 1000): exact quotient for every dividend below CLAMP_LIMIT
    localparam int DIV_RECIP   = ((2 ** DIV_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_FL = 4'd0,
        REG_GAIN_FL   = 4'd1,
        REG_OFFSET_FR = 4'd2,
        REG_GAIN_FR   = 4'd3,
        REG_OFFSET_SL = 4'd4,
        REG_GAIN_SL   = 4'd5,
        REG_OFFSET_SR = 4'd6,
        REG_GAIN_SR   = 4'd7
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RANK  = 6'b000010,
        ST_MULG  = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_STORE = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// File: rtl/four_channel_median_calibrator.sv
// Four-channel running median filter with offset/gain calibration. Each input
// transaction carries four 10-bit samples and the elapsed milliseconds; the
// very first one after reset fills the whole history of every channel, later
// ones are stored into the next history slot once the accumulated time reaches
// the store interval. Every input transaction yields exactly one result: per
// channel the median of its history, scaled as (median + offset) * gain / 1000
// (truncated toward zero) and clamped to 0..1023, plus a flag telling whether
// the samples were stored. From acceptance to result valid a transaction
// goes through rank counting (one median candidate per cycle, all channels
// at once), then per channel through the one shared multiplier (gain
// product, reciprocal scaling by 1/1000, write-back; a channel that clamps
// gets its clamped level in the scaling step and skips the write-back), and
// then through the load of the output register. The input is ready again in
// the cycle the result appears. The input is not ready while a transaction
// is being worked on; a finished result waits in the output register without
// blocking the next input, but that next transaction then holds in its
// output-load cycle, with the input not ready, until the waiting result is
// taken. Configuration writes are taken at any time, must only be issued
// while the block is idle, and indices 8..15 are ignored.
module four_channel_median_calibrator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fcmc_pkg::SAMPLE_W-1:0]       s_sample_front_left,
    input  logic [fcmc_pkg::SAMPLE_W-1:0]       s_sample_front_right,
    input  logic [fcmc_pkg::SAMPLE_W-1:0]       s_sample_side_left,
    input  logic [fcmc_pkg::SAMPLE_W-1:0]       s_sample_side_right,
    input  logic [fcmc_pkg::ELAPSED_W-1:0]      s_elapsed_ms,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fcmc_pkg::SAMPLE_W-1:0]       m_level_front_left,
    output logic [fcmc_pkg::SAMPLE_W-1:0]       m_level_front_right,
    output logic [fcmc_pkg::SAMPLE_W-1:0]       m_level_side_left,
    output logic [fcmc_pkg::SAMPLE_W-1:0]       m_level_side_right,
    output logic                                m_sample_taken
);

    fcmc_pkg::state_t state_reg;

    // Calibration registers
    logic signed [fcmc_pkg::OFFSET_W-1:0] off_reg  [fcmc_pkg::CHANNELS];
    logic [fcmc_pkg::GAIN_W-1:0]          gain_reg [fcmc_pkg::CHANNELS];

    // History rings and store bookkeeping
    logic [fcmc_pkg::SAMPLE_W-1:0] hist_reg [fcmc_pkg::CHANNELS][fcmc_pkg::SAMPLES];
    logic [fcmc_pkg::SLOT_W-1:0]   slot_reg;
    logic [fcmc_pkg::TIME_W-1:0]   time_reg;
    logic                          primed_reg;
    logic                          taken_reg;

    // Working registers
    logic [fcmc_pkg::SLOT_W-1:0]   cand_reg;
    logic [fcmc_pkg::CH_W-1:0]     ch_reg;
    logic [fcmc_pkg::SAMPLE_W-1:0] med_reg [fcmc_pkg::CHANNELS];
    logic [fcmc_pkg::SAMPLE_W-1:0] lvl_reg [fcmc_pkg::CHANNELS];
    logic [fcmc_pkg::PROD_W-1:0]   prod_reg;
    logic                          m_valid_reg;

    logic                          s_fire;
    logic [fcmc_pkg::SAMPLE_W-1:0] smp [fcmc_pkg::CHANNELS];
    logic [fcmc_pkg::TIME_W:0]     time_sum;
    logic                          store_hit;
    logic [fcmc_pkg::SLOT_W-1:0]   slot_next;

    logic [fcmc_pkg::SAMPLE_W-1:0] cand_val [fcmc_pkg::CHANNELS];
    logic [fcmc_pkg::RANK_W-1:0]   rank     [fcmc_pkg::CHANNELS];

    logic signed [fcmc_pkg::SUM_W-1:0] cal_sum;
    logic signed [fcmc_pkg::MUL_W-1:0] mul_a;
    logic signed [fcmc_pkg::MUL_W-1:0] mul_b;
    logic signed [fcmc_pkg::PROD_W-1:0] mul_prod;
    logic                          prod_neg;
    logic                          prod_big;
    logic                          last_ch;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == fcmc_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    assign smp[0] = s_sample_front_left;
    assign smp[1] = s_sample_front_right;
    assign smp[2] = s_sample_side_left;
    assign smp[3] = s_sample_side_right;

    // Store decision for an accepted transaction
    assign time_sum  = {1'b0, time_reg} + (fcmc_pkg::TIME_W + 1)'(s_elapsed_ms);
    assign store_hit = time_sum >= (fcmc_pkg::TIME_W + 1)'(fcmc_pkg::STORE_INTERVAL);
    assign slot_next = (slot_reg == fcmc_pkg::SLOT_W'(fcmc_pkg::SAMPLES - 1))
                     ? '0 : slot_reg + fcmc_pkg::SLOT_W'(1);

    // Rank of the current candidate within each ring; ties broken by position
    always_comb begin
        for (int c = 0; c < fcmc_pkg::CHANNELS; c++) begin
            cand_val[c] = hist_reg[c][cand_reg];
            rank[c]     = '0;
            for (int j = 0; j < fcmc_pkg::SAMPLES; j++) begin
                if ((hist_reg[c][j] < cand_val[c]) ||
                    ((hist_reg[c][j] == cand_val[c]) &&
                     (fcmc_pkg::SLOT_W'(j) < cand_reg))) begin
                    rank[c] = rank[c] + fcmc_pkg::RANK_W'(1);
                end
            end
        end
    end

    // Shared multiplier: gain product, then reciprocal scaling
    assign cal_sum = $signed({2'b00, med_reg[ch_reg]})
                   + $signed({{2{off_reg[ch_reg][fcmc_pkg::OFFSET_W-1]}}, off_reg[ch_reg]});

    always_comb begin
        if (state_reg == fcmc_pkg::ST_SCALE) begin
            mul_a = $signed({1'b0, prod_reg[fcmc_pkg::QUOT_W-1:0]});
            mul_b = $signed({1'b0, fcmc_pkg::QUOT_W'(fcmc_pkg::DIV_RECIP)});
        end else begin
            mul_a = $signed({{(fcmc_pkg::MUL_W - fcmc_pkg::SUM_W){cal_sum[fcmc_pkg::SUM_W-1]}},
                             cal_sum});
            mul_b = $signed({{(fcmc_pkg::MUL_W - fcmc_pkg::GAIN_W){1'b0}}, gain_reg[ch_reg]});
        end
    end

    assign mul_prod = mul_a * mul_b;
    assign prod_neg = prod_reg[fcmc_pkg::PROD_W-1];
    assign prod_big = prod_reg >= fcmc_pkg::PROD_W'(fcmc_pkg::CLAMP_LIMIT);
    assign last_ch  = (ch_reg == fcmc_pkg::CH_W'(fcmc_pkg::CHANNELS - 1));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < fcmc_pkg::CHANNELS; c++) begin
                off_reg[c]  <= '0;
                gain_reg[c] <= fcmc_pkg::GAIN_W'(fcmc_pkg::GAIN_RESET);
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                fcmc_pkg::REG_OFFSET_FL: off_reg[0]  <= cfg_data[fcmc_pkg::OFFSET_W-1:0];
                fcmc_pkg::REG_GAIN_FL:   gain_reg[0] <= cfg_data[fcmc_pkg::GAIN_W-1:0];
                fcmc_pkg::REG_OFFSET_FR: off_reg[1]  <= cfg_data[fcmc_pkg::OFFSET_W-1:0];
                fcmc_pkg::REG_GAIN_FR:   gain_reg[1] <= cfg_data[fcmc_pkg::GAIN_W-1:0];
                fcmc_pkg::REG_OFFSET_SL: off_reg[2]  <= cfg_data[fcmc_pkg::OFFSET_W-1:0];
                fcmc_pkg::REG_GAIN_SL:   gain_reg[2] <= cfg_data[fcmc_pkg::GAIN_W-1:0];
                fcmc_pkg::REG_OFFSET_SR: off_reg[3]  <= cfg_data[fcmc_pkg::OFFSET_W-1:0];
                fcmc_pkg::REG_GAIN_SR:   gain_reg[3] <= cfg_data[fcmc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // History rings: filled on first transaction, then one slot per store
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (!primed_reg) begin
                for (int c = 0; c < fcmc_pkg::CHANNELS; c++) begin
                    for (int k = 0; k < fcmc_pkg::SAMPLES; k++) begin
                        hist_reg[c][k] <= smp[c];
                    end
                end
            end else if (store_hit) begin
                for (int c = 0; c < fcmc_pkg::CHANNELS; c++) begin
                    hist_reg[c][slot_reg] <= smp[c];
                end
            end
        end
    end

    // Store bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            time_reg   <= '0;
            primed_reg <= 1'b0;
            taken_reg  <= 1'b0;
        end else if (s_fire) begin
            if (!primed_reg) begin
                slot_reg   <= '0;
                time_reg   <= '0;
                primed_reg <= 1'b1;
                taken_reg  <= 1'b1;
            end else if (store_hit) begin
                slot_reg  <= slot_next;
                time_reg  <= '0;
                taken_reg <= 1'b1;
            end else begin
                time_reg  <= time_sum[fcmc_pkg::TIME_W-1:0];
                taken_reg <= 1'b0;
            end
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcmc_pkg::ST_IDLE;
            cand_reg  <= '0;
            ch_reg    <= '0;
        end else begin
            unique case (state_reg)
                fcmc_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        cand_reg  <= '0;
                        state_reg <= fcmc_pkg::ST_RANK;
                    end
                end
                fcmc_pkg::ST_RANK: begin
                    if (cand_reg == fcmc_pkg::SLOT_W'(fcmc_pkg::SAMPLES - 1)) begin
                        ch_reg    <= '0;
                        state_reg <= fcmc_pkg::ST_MULG;
                    end else begin
                        cand_reg <= cand_reg + fcmc_pkg::SLOT_W'(1);
                    end
                end
                fcmc_pkg::ST_MULG: begin
                    state_reg <= fcmc_pkg::ST_SCALE;
                end
                fcmc_pkg::ST_SCALE: begin
                    if (prod_neg || prod_big) begin
                        ch_reg    <= ch_reg + fcmc_pkg::CH_W'(1);
                        state_reg <= last_ch ? fcmc_pkg::ST_OUT : fcmc_pkg::ST_MULG;
                    end else begin
                        state_reg <= fcmc_pkg::ST_STORE;
                    end
                end
                fcmc_pkg::ST_STORE: begin
                    ch_reg    <= ch_reg + fcmc_pkg::CH_W'(1);
                    state_reg <= last_ch ? fcmc_pkg::ST_OUT : fcmc_pkg::ST_MULG;
                end
                fcmc_pkg::ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= fcmc_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= fcmc_pkg::ST_IDLE;
            endcase
        end
    end

    // Median capture during ranking
    always_ff @(posedge aclk) begin
        if (state_reg == fcmc_pkg::ST_RANK) begin
            for (int c = 0; c < fcmc_pkg::CHANNELS; c++) begin
                if (rank[c] == fcmc_pkg::RANK_W'(fcmc_pkg::MEDIAN_RANK)) begin
                    med_reg[c] <= cand_val[c];
                end
            end
        end
    end

    // Product register and per-channel levels
    always_ff @(posedge aclk) begin
        if (state_reg == fcmc_pkg::ST_MULG) begin
            prod_reg <= mul_prod;
        end else if (state_reg == fcmc_pkg::ST_SCALE) begin
            priority if (prod_neg) begin
                lvl_reg[ch_reg] <= '0;
            end else if (prod_big) begin
                lvl_reg[ch_reg] <= fcmc_pkg::SAMPLE_W'(fcmc_pkg::LEVEL_MAX);
            end else begin
                prod_reg <= mul_prod;
            end
        end else if (state_reg == fcmc_pkg::ST_STORE) begin
            lvl_reg[ch_reg] <= prod_reg[fcmc_pkg::DIV_SHIFT +: fcmc_pkg::SAMPLE_W];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == fcmc_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == fcmc_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_level_front_left  <= lvl_reg[0];
            m_level_front_right <= lvl_reg[1];
            m_level_side_left   <= lvl_reg[2];
            m_level_side_right  <= lvl_reg[3];
            m_sample_taken      <= taken_reg;
        end
    end

endmodule

// File: rtl/fcmc_checker.sv
module fcmc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [fcmc_pkg::SAMPLE_W-1:0]       m_level_front_left,
    input logic                                m_sample_taken
);

    // Busy after every accepted input transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready right after a transaction");

    // A result never appears the cycle after an input transaction
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result raised too early");

    // A new result is only loaded at the end of processing, when input is busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised while block was idle");

    // Stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level_front_left)
                                && $stable(m_sample_taken))
        else $error("stalled result changed");

endmodule

bind four_channel_median_calibrator fcmc_checker u_fcmc_checker (.*);
